// ===== hw/rtl/xlce_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the list cursor editor.
package xlce_pkg;

  localparam int NODE_COUNT = 4096;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int CNT_W      = $clog2(NODE_COUNT + 1);
  localparam int MAG_BITS   = 43;
  localparam int VALUE_W    = 44;

  localparam logic [63:0] LIM_64 = (64'd1 << MAG_BITS) - 64'd1;
  localparam logic signed [VALUE_W-1:0] VAL_LIM  = VALUE_W'(LIM_64);
  localparam logic signed [VALUE_W-1:0] VAL_NLIM = -VAL_LIM;

  localparam logic [IDX_W-1:0] LEFT_SENT  = IDX_W'(0);
  localparam logic [IDX_W-1:0] RIGHT_SENT = IDX_W'(1);

  localparam logic [2:0] REQ_LEFT   = 3'd0;
  localparam logic [2:0] REQ_RIGHT  = 3'd1;
  localparam logic [2:0] REQ_SET    = 3'd2;
  localparam logic [2:0] REQ_INSERT = 3'd3;
  localparam logic [2:0] REQ_DELETE = 3'd4;
  localparam logic [2:0] REQ_READ   = 3'd5;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SENT = 2'd2;

  typedef enum logic [1:0] {
    RS_CUR, RS_PREV, RS_FREE, RS_NEXT
  } rsel_t;

  typedef enum logic [2:0] {
    WS_INS_NEW, WS_INS_CUR, WS_INS_PREV, WS_DEL_PREV, WS_DEL_NEXT, WS_DEL_CUR
  } wsel_t;

  typedef enum logic [1:0] {
    VW_SET, VW_INS, VW_DEL
  } vsel_t;

  typedef enum logic [2:0] {
    UP_NONE, UP_LEFT, UP_RIGHT, UP_INS, UP_DEL
  } upd_t;

  typedef struct packed {
    logic       cap_in;
    logic       link_rd;
    rsel_t      rd_sel;
    logic       ld_cur;
    logic       ld_a;
    logic       ld_b;
    logic       link_wr;
    wsel_t      wr_sel;
    logic       val_wr;
    vsel_t      vw_sel;
    upd_t       upd;
    logic       status_ld;
    logic [1:0] status_code;
    logic       val_rd;
    logic       out_ld;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       cur_left;
    logic       cur_right;
    logic       free_nonempty;
    logic       mem_full;
  } stat_t;

endpackage

// ===== hw/rtl/xlce_ctrl.sv =====
// Request sequencer of the list cursor editor: one-hot state machine and output valid.
module xlce_ctrl import xlce_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_RDC  = 10'b0000000010,
    S_CHK  = 10'b0000000100,
    S_RDA  = 10'b0000001000,
    S_RDB  = 10'b0000010000,
    S_WR1  = 10'b0000100000,
    S_WR2  = 10'b0001000000,
    S_WR3  = 10'b0010000000,
    S_VRD  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   is_ins;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign is_ins    = (stat.req == REQ_INSERT);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.rd_sel    = RS_CUR;
    cmd.wr_sel    = WS_INS_NEW;
    cmd.vw_sel    = VW_SET;
    cmd.upd       = UP_NONE;
    cmd.status_code = ST_DONE;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = S_RDC;
        end
      end
      S_RDC: begin
        cmd.link_rd = 1'b1;
        cmd.rd_sel  = RS_CUR;
        state_nxt   = S_CHK;
      end
      S_CHK: begin
        cmd.ld_cur    = 1'b1;
        cmd.status_ld = 1'b1;
        state_nxt     = S_VRD;
        unique case (stat.req)
          REQ_LEFT: begin
            if (stat.cur_left) cmd.status_code = ST_SENT;
            else cmd.upd = UP_LEFT;
          end
          REQ_RIGHT: begin
            if (stat.cur_right) cmd.status_code = ST_SENT;
            else cmd.upd = UP_RIGHT;
          end
          REQ_SET: begin
            if (stat.cur_left || stat.cur_right) cmd.status_code = ST_SENT;
            else begin
              cmd.val_wr = 1'b1;
              cmd.vw_sel = VW_SET;
            end
          end
          REQ_INSERT: begin
            if (stat.cur_left) cmd.status_code = ST_SENT;
            else if (stat.mem_full) cmd.status_code = ST_FULL;
            else begin
              cmd.link_rd = 1'b1;
              cmd.rd_sel  = RS_PREV;
              state_nxt   = S_RDA;
            end
          end
          REQ_DELETE: begin
            if (stat.cur_left || stat.cur_right) cmd.status_code = ST_SENT;
            else begin
              cmd.link_rd = 1'b1;
              cmd.rd_sel  = RS_PREV;
              state_nxt   = S_RDA;
            end
          end
          default: ;
        endcase
      end
      S_RDA: begin
        cmd.ld_a = 1'b1;
        if (is_ins) begin
          if (stat.free_nonempty) begin
            cmd.link_rd = 1'b1;
            cmd.rd_sel  = RS_FREE;
            state_nxt   = S_RDB;
          end else begin
            state_nxt = S_WR1;
          end
        end else begin
          cmd.link_rd = 1'b1;
          cmd.rd_sel  = RS_NEXT;
          state_nxt   = S_RDB;
        end
      end
      S_RDB: begin
        cmd.ld_b  = 1'b1;
        state_nxt = S_WR1;
      end
      S_WR1: begin
        cmd.link_wr = 1'b1;
        cmd.val_wr  = 1'b1;
        cmd.wr_sel  = is_ins ? WS_INS_NEW : WS_DEL_PREV;
        cmd.vw_sel  = is_ins ? VW_INS : VW_DEL;
        state_nxt   = S_WR2;
      end
      S_WR2: begin
        cmd.link_wr = 1'b1;
        cmd.wr_sel  = is_ins ? WS_INS_CUR : WS_DEL_NEXT;
        state_nxt   = S_WR3;
      end
      S_WR3: begin
        cmd.link_wr = 1'b1;
        cmd.wr_sel  = is_ins ? WS_INS_PREV : WS_DEL_CUR;
        cmd.upd     = is_ins ? UP_INS : UP_DEL;
        state_nxt   = S_VRD;
      end
      S_VRD: begin
        cmd.val_rd = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/xlce_dp.sv =====
// Datapath of the list cursor editor: node memories, cursor, free list and result register.
module xlce_dp import xlce_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  output stat_t                     stat,
  input  logic [2:0]                in_req_type,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic [1:0]                out_status,
  output logic signed [VALUE_W-1:0] out_read_value
);

  logic [IDX_W-1:0]          link_mem [NODE_COUNT];
  logic signed [VALUE_W-1:0] val_mem  [NODE_COUNT];

  logic [IDX_W-1:0] sent0_r, sent1_r;
  logic [IDX_W-1:0] cursor_r, cfn_r, free_head_r;
  logic             cfl_r;
  logic [CNT_W-1:0] free_cnt_r, next_unused_r;

  logic [2:0]                req_r;
  logic signed [VALUE_W-1:0] val_r, val_q_r;
  logic [1:0]                status_r;
  logic [IDX_W-1:0]          mem_q_r, sent_q_r;
  logic                      sel_sent_r;
  logic [IDX_W-1:0]          lcur_r, prev_r, next_r, lpv_r, lb_r;

  logic [IDX_W-1:0]          link_q, prev_c, next_c, nw_c, rd_addr, wr_addr, wr_data;
  logic [IDX_W-1:0]          vw_addr;
  logic signed [VALUE_W-1:0] vw_data, sat_val;
  logic                      free_ne;

  assign link_q  = sel_sent_r ? sent_q_r : mem_q_r;
  assign prev_c  = cfl_r ? cfn_r : (link_q ^ cfn_r);
  assign next_c  = cfl_r ? (link_q ^ cfn_r) : cfn_r;
  assign free_ne = (free_cnt_r != '0);
  assign nw_c    = free_ne ? free_head_r : next_unused_r[IDX_W-1:0];

  assign stat.req           = req_r;
  assign stat.cur_left      = (cursor_r == LEFT_SENT);
  assign stat.cur_right     = (cursor_r == RIGHT_SENT);
  assign stat.free_nonempty = free_ne;
  assign stat.mem_full      = !free_ne && (next_unused_r >= CNT_W'(NODE_COUNT));

  // Values are clamped symmetrically so that the most negative code never enters.
  always_comb begin
    if (in_value > VAL_LIM) sat_val = VAL_LIM;
    else if (in_value < VAL_NLIM) sat_val = VAL_NLIM;
    else sat_val = in_value;
  end

  always_comb begin
    unique case (cmd.rd_sel)
      RS_CUR:  rd_addr = cursor_r;
      RS_PREV: rd_addr = prev_c;
      RS_FREE: rd_addr = free_head_r;
      RS_NEXT: rd_addr = next_r;
      default: rd_addr = cursor_r;
    endcase
  end

  always_comb begin
    wr_addr = nw_c;
    wr_data = prev_r ^ cursor_r;
    unique case (cmd.wr_sel)
      WS_INS_NEW: begin
        wr_addr = nw_c;
        wr_data = prev_r ^ cursor_r;
      end
      WS_INS_CUR: begin
        wr_addr = cursor_r;
        wr_data = lcur_r ^ prev_r ^ nw_c;
      end
      WS_INS_PREV: begin
        wr_addr = prev_r;
        wr_data = lpv_r ^ cursor_r ^ nw_c;
      end
      WS_DEL_PREV: begin
        wr_addr = prev_r;
        wr_data = lpv_r ^ cursor_r ^ next_r;
      end
      WS_DEL_NEXT: begin
        wr_addr = next_r;
        wr_data = lb_r ^ cursor_r ^ prev_r;
      end
      WS_DEL_CUR: begin
        wr_addr = cursor_r;
        wr_data = free_head_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (cmd.vw_sel)
      VW_SET: begin
        vw_addr = cursor_r;
        vw_data = val_r;
      end
      VW_INS: begin
        vw_addr = nw_c;
        vw_data = val_r;
      end
      VW_DEL: begin
        vw_addr = cursor_r;
        vw_data = '0;
      end
      default: begin
        vw_addr = cursor_r;
        vw_data = '0;
      end
    endcase
  end

  // Node memories; the two sentinel links live in registers with a defined reset.
  always_ff @(posedge clk) begin
    if (cmd.link_wr && (wr_addr[IDX_W-1:1] != '0)) link_mem[wr_addr] <= wr_data;
    if (cmd.link_rd) begin
      mem_q_r    <= link_mem[rd_addr];
      sel_sent_r <= (rd_addr[IDX_W-1:1] == '0);
      sent_q_r   <= rd_addr[0] ? sent1_r : sent0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.val_wr) val_mem[vw_addr] <= vw_data;
    if (cmd.val_rd) val_q_r <= val_mem[cursor_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      req_r <= in_req_type;
      val_r <= sat_val;
    end
    if (cmd.status_ld) status_r <= cmd.status_code;
    if (cmd.ld_cur) begin
      lcur_r <= link_q;
      prev_r <= prev_c;
      next_r <= next_c;
    end
    if (cmd.ld_a) lpv_r <= link_q;
    if (cmd.ld_b) lb_r <= link_q;
    if (cmd.out_ld) begin
      out_status     <= status_r;
      out_read_value <= (cursor_r[IDX_W-1:1] == '0) ? '0 : val_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent0_r       <= RIGHT_SENT;
      sent1_r       <= LEFT_SENT;
      cursor_r      <= RIGHT_SENT;
      cfn_r         <= LEFT_SENT;
      cfl_r         <= 1'b0;
      free_head_r   <= '0;
      free_cnt_r    <= '0;
      next_unused_r <= CNT_W'(2);
    end else begin
      if (cmd.link_wr && (wr_addr == LEFT_SENT))  sent0_r <= wr_data;
      if (cmd.link_wr && (wr_addr == RIGHT_SENT)) sent1_r <= wr_data;
      unique case (cmd.upd)
        UP_NONE: ;
        UP_LEFT: begin
          cursor_r <= prev_c;
          cfn_r    <= cursor_r;
          cfl_r    <= 1'b0;
        end
        UP_RIGHT: begin
          cursor_r <= next_c;
          cfn_r    <= cursor_r;
          cfl_r    <= 1'b1;
        end
        UP_INS: begin
          if (free_ne) begin
            free_head_r <= lb_r;
            free_cnt_r  <= free_cnt_r - CNT_W'(1);
          end else begin
            next_unused_r <= next_unused_r + CNT_W'(1);
          end
          cursor_r <= nw_c;
          cfn_r    <= cursor_r;
          cfl_r    <= 1'b0;
        end
        UP_DEL: begin
          free_head_r <= cursor_r;
          free_cnt_r  <= free_cnt_r + CNT_W'(1);
          cursor_r    <= next_r;
          cfn_r       <= prev_r;
          cfl_r       <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/xor_linked_list_cursor_editor_top.sv =====
// Top level of the XOR linked list cursor editor: sequencer plus datapath.
//
// The block holds an ordered list of signed 44-bit values between two sentinel
// nodes, each node storing the XOR of its neighbors' indices. An input item
// (in_req_type, in_value) moves the cursor left or right, sets the value under
// it, inserts a node to its left, deletes the node under it, or reads it.
// Every accepted item yields exactly one result item (out_status,
// out_read_value) carrying the value under the cursor after the request.
// Both channels use valid/ready; an item moves when valid and ready are high.
// Items are handled one at a time. Moves, set, read and refused requests read
// and check the cursor link, then read the value; an insert also reads the link
// of the node to its left and, if the free list is not empty, its head, and a
// delete reads both neighbor links; both then rewrite three links. The steps are
// set by the single-port link memory: every neighbor link is read and then
// rewritten one word per cycle, followed by one value memory read.
// The result register lets the next item be accepted while a result waits;
// if the receiver stalls, that next item completes its work and holds in the
// final step until the result register frees up.
// Synchronous active-low reset links the sentinels, empties the free list and
// puts the cursor on the right sentinel; no memory clearing pass is needed.
module xor_linked_list_cursor_editor_top import xlce_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                in_req_type,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output logic signed [VALUE_W-1:0] out_read_value
);

  cmd_t  cmd;
  stat_t stat;

  // The sequencer owns the handshakes; the datapath owns every stored value.
  xlce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  xlce_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_req_type    (in_req_type),
    .in_value       (in_value),
    .out_status     (out_status),
    .out_read_value (out_read_value)
  );

endmodule
